// ===== hw/rtl/eld_pkg.sv =====
package eld_pkg;

	// One slot of the queue between the byte decoder and the output stage.
	// A byte yields one or two code points; bytes that yield none are not queued.
	typedef struct packed {
		logic        two;
		logic [31:0] first_cp;
		logic [31:0] second_cp;
		logic        last;
	} entry_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hw/rtl/escape_literal_decoder.sv =====
// Decodes the body of a C-style character or string literal, one byte per
// transaction on the input channel, into Unicode code points on the output
// channel. Escapes (simple, octal, \x, \u, \U) and multi-byte UTF-8 are
// resolved; malformed UTF-8 gives U+FFFD. A transaction with end_of_body set
// closes the literal: any pending escape or sequence is flushed, the last code
// point of that literal carries final_point, and decoding restarts clean for
// the next literal. A byte may produce no, one or two code points. The input
// side takes one byte per cycle whenever the four-entry queue between the
// byte decoder and the output stage has room; the output stage delivers one
// code point per cycle while out_ready is high, so a byte that yields two
// code points holds the output stage while both are delivered, and the queue
// absorbs the difference. An accepted byte is decoded into the queue and then
// loaded into the output register.
module escape_literal_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  body_byte,
	input  logic        end_of_body,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] scalar_value,
	output logic        final_point
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            q_not_full;
	logic            q_not_empty;
	eld_pkg::entry_t push_entry;
	eld_pkg::entry_t q_head;

	// A byte is only taken when its results are sure to find a queue slot.
	assign in_ready = q_not_full;
	assign accept   = in_valid && in_ready;

	eld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.body_byte   (body_byte),
		.end_of_body (end_of_body),
		.push        (push),
		.push_entry  (push_entry)
	);

	eld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_not_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	eld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scalar_value (scalar_value),
		.final_point  (final_point)
	);

endmodule

// ===== hw/rtl/eld_front.sv =====
module eld_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      body_byte,
	input  logic            end_of_body,
	output logic            push,
	output eld_pkg::entry_t push_entry
);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_ESCAPE = 3'd1,
		M_OCTAL  = 3'd2,
		M_HEX    = 3'd3,
		M_UNIV   = 3'd4,
		M_UTF8   = 3'd5
	} mode_t;

	localparam logic [31:0] REPLACEMENT = 32'h0000_FFFD;
	localparam logic [7:0]  BACKSLASH   = 8'h5C;

	mode_t       mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [3:0]  lim_q, lim_d;
	logic [1:0]  rem_q, rem_d;

	logic        e0, e1, ne, norm, ok, full;
	logic [31:0] v0, v1, nv;
	logic [4:0]  nib;

	// Hex digit value, or 16 when the byte is no hex digit.
	function automatic logic [4:0] nib_of(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd16;
		if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h61 + 8'd10);
		else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h41 + 8'd10);
		return r;
	endfunction

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		lim_d  = lim_q;
		rem_d  = rem_q;
		e0     = 1'b0;
		v0     = '0;
		e1     = 1'b0;
		v1     = '0;
		ne     = 1'b0;
		nv     = '0;
		norm   = 1'b0;
		ok     = 1'b0;
		full   = 1'b0;
		nib    = nib_of(body_byte);

		unique case (mode_q)
			M_ESCAPE: begin
				mode_d = M_NORMAL;
				acc_d  = '0;
				cnt_d  = '0;
				unique case (body_byte)
					8'h6E: begin e0 = 1'b1; v0 = 32'h0A; end
					8'h72: begin e0 = 1'b1; v0 = 32'h0D; end
					8'h74: begin e0 = 1'b1; v0 = 32'h09; end
					8'h61: begin e0 = 1'b1; v0 = 32'h07; end
					8'h62: begin e0 = 1'b1; v0 = 32'h08; end
					8'h66: begin e0 = 1'b1; v0 = 32'h0C; end
					8'h76: begin e0 = 1'b1; v0 = 32'h0B; end
					8'h78: begin
						mode_d = M_HEX;
						e0     = end_of_body;
					end
					8'h75, 8'h55: begin
						mode_d = M_UNIV;
						lim_d  = (body_byte == 8'h75) ? 4'd4 : 4'd8;
						e0     = end_of_body;
					end
					default: begin
						if (body_byte >= 8'h30 && body_byte <= 8'h37) begin
							mode_d = M_OCTAL;
							acc_d  = {29'd0, body_byte[2:0]};
							cnt_d  = 4'd1;
							lim_d  = 4'd3;
							e0     = end_of_body;
							v0     = {29'd0, body_byte[2:0]};
						end else begin
							// Backslash, quotes, question mark and unknown escapes
							// all give the byte itself.
							e0 = 1'b1;
							v0 = {24'd0, body_byte};
						end
					end
				endcase
			end
			M_OCTAL, M_HEX, M_UNIV: begin
				ok = (mode_q == M_OCTAL) ? (nib < 5'd8) : !nib[4];
				if (ok) begin
					acc_d = (mode_q == M_OCTAL) ? {acc_q[28:0], nib[2:0]}
					                            : {acc_q[27:0], nib[3:0]};
					if (mode_q != M_HEX) begin
						cnt_d = cnt_q + 4'd1;
						if (cnt_d >= lim_q) begin
							full   = 1'b1;
							e0     = 1'b1;
							v0     = acc_d;
							mode_d = M_NORMAL;
						end
					end
					if (!full && end_of_body) begin
						e0 = 1'b1;
						v0 = acc_d;
					end
				end else begin
					e0   = 1'b1;
					v0   = acc_q;
					norm = 1'b1;
				end
			end
			M_UTF8: begin
				if (body_byte[7:6] == 2'b10) begin
					acc_d = {acc_q[25:0], body_byte[5:0]};
					rem_d = rem_q - 2'd1;
					if (rem_d == 2'd0) begin
						e0     = 1'b1;
						v0     = acc_d;
						mode_d = M_NORMAL;
					end else if (end_of_body) begin
						e0 = 1'b1;
						v0 = REPLACEMENT;
					end
				end else begin
					e0    = 1'b1;
					v0    = REPLACEMENT;
					rem_d = '0;
					norm  = 1'b1;
				end
			end
			default: norm = 1'b1;
		endcase

		// Plain decode of the byte, also used for a byte that ended a pending
		// escape or broke a UTF-8 sequence.
		if (norm) begin
			mode_d = M_NORMAL;
			if (body_byte == BACKSLASH) begin
				if (end_of_body) begin
					ne = 1'b1;
					nv = {24'd0, BACKSLASH};
				end else begin
					mode_d = M_ESCAPE;
				end
			end else if (!body_byte[7]) begin
				ne = 1'b1;
				nv = {24'd0, body_byte};
			end else if (body_byte >= 8'hC2 && body_byte <= 8'hF4) begin
				if (body_byte <= 8'hDF) begin
					rem_d = 2'd1;
					acc_d = {27'd0, body_byte[4:0]};
				end else if (body_byte <= 8'hEF) begin
					rem_d = 2'd2;
					acc_d = {28'd0, body_byte[3:0]};
				end else begin
					rem_d = 2'd3;
					acc_d = {29'd0, body_byte[2:0]};
				end
				if (end_of_body) begin
					ne = 1'b1;
					nv = REPLACEMENT;
				end else begin
					mode_d = M_UTF8;
				end
			end else begin
				ne = 1'b1;
				nv = REPLACEMENT;
			end
			if (e0) begin
				e1 = ne;
				v1 = nv;
			end else begin
				e0 = ne;
				v0 = nv;
			end
		end

		if (end_of_body) begin
			mode_d = M_NORMAL;
			acc_d  = '0;
			cnt_d  = '0;
			lim_d  = '0;
			rem_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			acc_q  <= '0;
			cnt_q  <= '0;
			lim_q  <= '0;
			rem_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			lim_q  <= lim_d;
			rem_q  <= rem_d;
		end
	end

	assign push                 = accept && e0;
	assign push_entry.two       = e1;
	assign push_entry.first_cp  = v0;
	assign push_entry.second_cp = v1;
	assign push_entry.last      = end_of_body;

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_body) |=> (mode_q == M_NORMAL && rem_q == 2'd0))
		else $error("decoder state not cleared after the final byte");
	a_utf8_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_UTF8) |-> (rem_q != 2'd0))
		else $error("UTF-8 mode with no continuation bytes expected");
`endif

endmodule

// ===== hw/rtl/eld_queue.sv =====
module eld_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  eld_pkg::entry_t push_entry,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output eld_pkg::entry_t head
);

	eld_pkg::entry_t                  slot_q [eld_pkg::QUEUE_DEPTH];
	logic [eld_pkg::QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [eld_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != eld_pkg::QUEUE_CNT_W'(eld_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
`endif

endmodule

// ===== hw/rtl/eld_back.sv =====
module eld_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  eld_pkg::entry_t q_head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     scalar_value,
	output logic            final_point
);

	eld_pkg::entry_t ent_q;
	logic            have_q;
	logic            idx_q;
	logic            at_end;
	logic            done;

	assign at_end = (idx_q == ent_q.two);
	assign done   = have_q && out_ready && at_end;
	assign pop    = q_not_empty && (!have_q || done);

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (pop) begin
			have_q <= 1'b1;
			idx_q  <= 1'b0;
		end else if (done) begin
			have_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (have_q && out_ready) begin
			idx_q <= 1'b1;
		end
	end

	assign out_valid    = have_q;
	assign scalar_value = idx_q ? ent_q.second_cp : ent_q.first_cp;
	assign final_point  = ent_q.last && at_end;

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Run length and the limits that guard it. The worst case per byte is a long
	// input gap plus two code points, each of which can wait out a long output
	// stall, so the cycle limit sits several times above the slowest correct run.
	localparam int RANDOM_BYTES = 950;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	// Characters and code points with a special meaning to the decoder.
	localparam logic [7:0]  BACKSLASH   = 8'h5C;
	localparam logic [31:0] LF          = 32'h0A;
	localparam logic [31:0] CR          = 32'h0D;
	localparam logic [31:0] TAB         = 32'h09;
	localparam logic [31:0] BEL         = 32'h07;
	localparam logic [31:0] BS          = 32'h08;
	localparam logic [31:0] FF          = 32'h0C;
	localparam logic [31:0] VT          = 32'h0B;
	localparam logic [31:0] REPLACEMENT = 32'hFFFD;
	localparam logic [4:0]  NOT_A_DIGIT = 5'd16;

	typedef enum logic [2:0] {
		DEC_NORMAL,
		DEC_ESCAPE,
		DEC_OCTAL,
		DEC_HEX,
		DEC_UNIV,
		DEC_UTF8
	} dec_mode_t;

	typedef struct packed {
		logic [31:0] cp;
		logic        fin;
	} point_t;

	// The scoreboard mirrors the decoder's state. Every accepted byte is run
	// through the same decode rules, and the code points it yields are queued
	// in order; every code point leaving the block is compared with the oldest.
	class literal_scoreboard;
		dec_mode_t   mode;
		logic [31:0] acc;
		logic [3:0]  ndigits;
		logic [3:0]  max_digits;
		logic [1:0]  utf8_left;
		point_t      points_due[$];
		point_t      step_points[$];
		int          bytes_seen;
		int          points_seen;
		int          literals_seen;
		int          failures;

		function new();
			clear_state();
			bytes_seen    = 0;
			points_seen   = 0;
			literals_seen = 0;
			failures      = 0;
		endfunction

		function void clear_state();
			mode       = DEC_NORMAL;
			acc        = '0;
			ndigits    = '0;
			max_digits = '0;
			utf8_left  = '0;
		endfunction

		function void emit(logic [31:0] v);
			point_t p;
			if (step_points.size() < 2) begin
				p.cp  = v;
				p.fin = 1'b0;
				step_points.insert(step_points.size(), p);
			end
		endfunction

		function logic [4:0] hex_value(logic [7:0] b);
			if (b >= "0" && b <= "9")
				return 5'(b - "0");
			if (b >= "a" && b <= "f")
				return 5'(b - "a" + 8'd10);
			if (b >= "A" && b <= "F")
				return 5'(b - "A" + 8'd10);
			return NOT_A_DIGIT;
		endfunction

		function void plain_byte(logic [7:0] b, logic last);
			mode = DEC_NORMAL;
			if (b == BACKSLASH) begin
				if (last)
					emit(32'(BACKSLASH));
				else
					mode = DEC_ESCAPE;
			end else if (b < 8'h80) begin
				emit(32'(b));
			end else if (b >= 8'hC2 && b <= 8'hF4) begin
				if (b <= 8'hDF) begin
					utf8_left = 2'd1;
					acc       = 32'(b[4:0]);
				end else if (b <= 8'hEF) begin
					utf8_left = 2'd2;
					acc       = 32'(b[3:0]);
				end else begin
					utf8_left = 2'd3;
					acc       = 32'(b[2:0]);
				end
				if (last)
					emit(REPLACEMENT);
				else
					mode = DEC_UTF8;
			end else begin
				emit(REPLACEMENT);
			end
		endfunction

		function void escape_byte(logic [7:0] b, logic last);
			logic [31:0] v;
			mode    = DEC_NORMAL;
			acc     = '0;
			ndigits = '0;
			case (b)
				"n": v = LF;
				"r": v = CR;
				"t": v = TAB;
				"a": v = BEL;
				"b": v = BS;
				"f": v = FF;
				"v": v = VT;
				BACKSLASH, "'", "\"", "?": v = 32'(b);
				"x": begin
					mode = DEC_HEX;
					if (last)
						emit('0);
					return;
				end
				"u", "U": begin
					mode       = DEC_UNIV;
					max_digits = (b == "u") ? 4'd4 : 4'd8;
					if (last)
						emit('0);
					return;
				end
				default: begin
					if (b >= "0" && b <= "7") begin
						mode       = DEC_OCTAL;
						acc        = 32'(b - "0");
						ndigits    = 4'd1;
						max_digits = 4'd3;
						if (last)
							emit(acc);
						return;
					end
					v = 32'(b);
				end
			endcase
			emit(v);
		endfunction

		function void digit_byte(logic [7:0] b, logic last);
			logic [4:0] d;
			logic       ok;
			d  = hex_value(b);
			ok = (mode == DEC_OCTAL) ? (d < 5'd8) : (d < 5'd16);
			if (ok) begin
				if (mode == DEC_OCTAL)
					acc = {acc[28:0], d[2:0]};
				else
					acc = {acc[27:0], d[3:0]};
				if (mode != DEC_HEX) begin
					ndigits = ndigits + 4'd1;
					if (ndigits >= max_digits) begin
						emit(acc);
						mode = DEC_NORMAL;
						return;
					end
				end
				if (last)
					emit(acc);
			end else begin
				emit(acc);
				plain_byte(b, last);
			end
		endfunction

		function void continuation_byte(logic [7:0] b, logic last);
			if (b >= 8'h80 && b <= 8'hBF) begin
				acc       = {acc[25:0], b[5:0]};
				utf8_left = utf8_left - 2'd1;
				if (utf8_left == 2'd0) begin
					emit(acc);
					mode = DEC_NORMAL;
				end else if (last) begin
					emit(REPLACEMENT);
				end
			end else begin
				emit(REPLACEMENT);
				utf8_left = 2'd0;
				plain_byte(b, last);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			step_points.delete();
			case (mode)
				DEC_ESCAPE:                   escape_byte(b, last);
				DEC_OCTAL, DEC_HEX, DEC_UNIV: digit_byte(b, last);
				DEC_UTF8:                     continuation_byte(b, last);
				default:                      plain_byte(b, last);
			endcase
			if (last) begin
				if (step_points.size() > 0)
					step_points[step_points.size() - 1].fin = 1'b1;
				clear_state();
				literals_seen++;
			end
			foreach (step_points[i])
				points_due.insert(points_due.size(), step_points[i]);
			bytes_seen++;
		endfunction

		function void check_point(logic [31:0] cp, logic fin);
			point_t want;
			points_seen++;
			if (points_due.size() == 0) begin
				$error("code point %h (final_point %b) arrived with none outstanding", cp, fin);
				failures++;
				return;
			end
			want = points_due.pop_front();
			if (cp !== want.cp) begin
				$error("scalar_value: expected %h, actual %h", want.cp, cp);
				failures++;
			end
			if (fin !== want.fin) begin
				$error("final_point: expected %b, actual %b", want.fin, fin);
				failures++;
			end
		endfunction

		function int pending();
			return points_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  body_byte;
	logic        end_of_body;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] scalar_value;
	logic        final_point;

	literal_scoreboard sb;
	logic [7:0]        lit[$];
	logic              idle_on;
	int                bytes_sent;
	int                cycles;

	escape_literal_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.body_byte    (body_byte),
		.end_of_body  (end_of_body),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scalar_value (scalar_value),
		.final_point  (final_point)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Gap lengths for both channels: mostly none or short, occasionally long.
	// While idle_on is low neither side pauses at all, which gives back-to-back
	// stretches that fill the block's internal queue.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// One byte on the input channel. Valid is only dropped when a gap is taken,
	// so with no gap the next byte follows in the very cycle after acceptance
	// and in_valid receives exactly one assignment in that time step.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		body_byte   <= b;
		end_of_body <= last;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	// Sends the bytes gathered in lit as one literal, marking the final byte.
	task automatic send_literal();
		foreach (lit[i])
			send_byte(lit[i], i == lit.size() - 1);
		lit.delete();
	endtask

	// Appends one byte to the literal being built.
	function automatic void add_byte(input logic [7:0] b);
		lit.insert(lit.size(), b);
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return 8'("0" + r);
		if (r < 16)
			return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	function automatic logic [7:0] utf8_lead(int len);
		case (len)
			2:       return 8'($urandom_range(8'hC2, 8'hDF));
			3:       return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF4));
		endcase
	endfunction

	// Appends one token of literal text. Most tokens are well-formed escapes
	// and UTF-8 sequences with random content, so that the numeric and
	// multi-byte states are reached often; the remainder are unknown escapes,
	// broken sequences and arbitrary bytes.
	function automatic void add_token();
		string      simple_set;
		int         kind;
		int         len;
		logic [7:0] c;
		simple_set = "nrtabfv\\'\"?";
		kind       = $urandom_range(0, 99);
		if (kind < 25) begin
			c = 8'($urandom_range(0, 127));
			add_byte((c == BACKSLASH) ? 8'("A") : c);
		end else if (kind < 35) begin
			add_byte(BACKSLASH);
			add_byte(simple_set[$urandom_range(0, 10)]);
		end else if (kind < 45) begin
			// The fourth digit, when drawn, follows a completed escape.
			add_byte(BACKSLASH);
			repeat ($urandom_range(1, 4))
				add_byte(8'("0" + $urandom_range(0, 7)));
		end else if (kind < 55) begin
			// More than eight digits makes the value wrap.
			add_byte(BACKSLASH);
			add_byte("x");
			repeat ($urandom_range(0, 12))
				add_byte(hex_char());
		end else if (kind < 62) begin
			add_byte(BACKSLASH);
			add_byte("u");
			repeat ($urandom_range(0, 5))
				add_byte(hex_char());
		end else if (kind < 69) begin
			add_byte(BACKSLASH);
			add_byte("U");
			repeat ($urandom_range(0, 9))
				add_byte(hex_char());
		end else if (kind < 84) begin
			len = $urandom_range(2, 4);
			add_byte(utf8_lead(len));
			repeat (len - 1)
				add_byte(8'($urandom_range(8'h80, 8'hBF)));
		end else if (kind < 90) begin
			// A sequence cut short, or a byte that can never lead one.
			if ($urandom_range(0, 1)) begin
				len = $urandom_range(2, 4);
				add_byte(utf8_lead(len));
				repeat ($urandom_range(0, len - 2))
					add_byte(8'($urandom_range(8'h80, 8'hBF)));
			end else begin
				c = 8'($urandom_range(8'h80, 8'hFF));
				add_byte(c);
			end
		end else if (kind < 95) begin
			add_byte(BACKSLASH);
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	// Both channels are sampled at the rising edge, before the driver's
	// nonblocking updates of that edge land. A code point can never leave in
	// the same cycle as the byte that caused it, so noting the input
	// transaction first keeps the expected order.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_byte(body_byte, end_of_body);
		if (arst_n && out_valid && out_ready)
			sb.check_point(scalar_value, final_point);
	end

	// Output back-pressure: a stall is started now and then, its length drawn
	// from the same short-or-long mix as the input gaps.
	initial begin
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d code points still due", cycles, sb.pending());
			$display("** escape_literal_decoder: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		body_byte   = '0;
		end_of_body = 1'b0;
		idle_on     = 1'b1;
		bytes_sent  = 0;
		cycles      = 0;
		sb          = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed literals. The extremes of the byte range, a plain escape,
		// unknown escapes including one above 0x7F, a full octal escape followed
		// by a further digit, a hex escape ended by a non-digit, a full \u escape,
		// a lone backslash at the end, \U with no digits at the end, a bad
		// continuation byte and a sequence truncated by the end of the literal.
		lit = {8'h00, 8'h7F, 8'hFF};
		send_literal();
		lit = {BACKSLASH, 8'("n"), BACKSLASH, 8'("8"), BACKSLASH, 8'hE9};
		send_literal();
		lit = {BACKSLASH, 8'("1"), 8'("7"), 8'("7"), 8'("7")};
		send_literal();
		lit = {BACKSLASH, 8'("x"), 8'("4"), 8'("g")};
		send_literal();
		lit = {BACKSLASH, 8'("u"), 8'("2"), 8'("0"), 8'("a"), 8'("C")};
		send_literal();
		lit = {BACKSLASH};
		send_literal();
		lit = {BACKSLASH, 8'("U")};
		send_literal();
		lit = {8'hC3, 8'h41};
		send_literal();
		lit = {8'hE2, 8'h82};
		send_literal();

		// Random literals of a few tokens each. Roughly one literal in six runs
		// with no pauses on either side; some literals end in a lone backslash.
		while (bytes_sent < RANDOM_BYTES + 31) begin
			idle_on = ($urandom_range(0, 5) != 0);
			repeat ($urandom_range(1, 8))
				add_token();
			if ($urandom_range(0, 7) == 0)
				add_byte(BACKSLASH);
			send_literal();
		end
		idle_on  = 1'b1;
		in_valid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Decoded %0d literals: %0d body bytes in, %0d code points checked.",
			sb.literals_seen, sb.bytes_seen, sb.points_seen);
		if (sb.failures == 0)
			$display("** escape_literal_decoder: PASSED **");
		else
			$display("** escape_literal_decoder: FAILED **");
		$finish;
	end

endmodule
